// File: hdl/assert_macros.svh
// Assertion helpers for the sprite quad expander checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SQE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sqe_checker: %m violated");

// Next-cycle implication, disabled while reset is asserted.
`define SQE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sqe_checker: %m violated");

`endif

// File: hdl/sqe_pkg.sv
package sqe_pkg;

    // Defaults for the top-level parameters.
    localparam int TABLE_BITS_DEF = 8;
    localparam int TRIG_FRAC_DEF  = 14;
    localparam int TRIG_FRAC_MAX  = 16;

    // Datapath widths, sized for the widest fraction setting.
    localparam int SINE_W = TRIG_FRAC_MAX + 1;      // table entry, 0 .. 2^frac
    localparam int TRIG_W = TRIG_FRAC_MAX + 2;      // signed cos / sin
    localparam int HALF_W = 30;                     // size >> 1
    localparam int PROD_W = HALF_W + 1 + TRIG_W;    // half extent times trig
    localparam int SUM_W  = PROD_W + 2;             // two products plus rounding
    localparam int OFS_W  = 34;                     // rotated offset after shift
    localparam int POS_W  = OFS_W + 1;              // center plus offset

    // Corner masks, bit i for corner i.
    localparam logic [3:0] LEFT_CORNERS   = 4'b1001;
    localparam logic [3:0] BOTTOM_CORNERS = 4'b0011;
    localparam logic [1:0] FIRST_CORNER   = 2'd0;
    localparam logic [1:0] LAST_CORNER    = 2'd3;

    // Table build constants: pi/2 in Q30 and the Taylor series divisors.
    localparam logic [63:0] HALFPI_Q30 = 64'd1686629713;
    localparam logic [63:0] SERIES_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                              64'd110, 64'd156, 64'd210, 64'd272};

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic [30:0]        size_x;
        logic [30:0]        size_y;
        logic [15:0]        angle;
        logic [15:0]        u_first;
        logic [15:0]        v_first;
        logic [15:0]        u_second;
        logic [15:0]        v_second;
        logic [31:0]        tint;
        logic               first_of_batch;
    } sprite_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        tex_u;
        logic [15:0]        tex_v;
        logic signed [15:0] tangent_x;
        logic signed [15:0] tangent_y;
        logic [31:0]        vertex_tint;
        logic [31:0]        vertex_number;
        logic [1:0]         corner;
        logic               last;
    } vertex_t;

    // Per-sprite values that ride along the pipeline untouched.
    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [15:0] tangent_x;
        logic signed [15:0] tangent_y;
        logic [15:0]        u_first;
        logic [15:0]        v_first;
        logic [15:0]        u_second;
        logic [15:0]        v_second;
        logic [31:0]        tint;
        logic               first_of_batch;
    } sprite_attr_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_val;
        logic signed [TRIG_W-1:0] sin_val;
        logic [HALF_W-1:0]        half_x;
        logic [HALF_W-1:0]        half_y;
        sprite_attr_t             attr;
    } trig_item_t;

    typedef struct packed {
        logic [3:0][OFS_W-1:0] off_x;
        logic [3:0][OFS_W-1:0] off_y;
        sprite_attr_t          attr;
    } rot_item_t;

    // Rounded sine table entry k, built at elaboration.
    function automatic logic [SINE_W-1:0] sine_entry(input int table_bits,
                                                     input int frac_bits,
                                                     input int k);
        logic [63:0]        n_entries;
        logic [63:0]        one;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        e;
        logic signed [63:0] sum;
        n_entries = 64'd1 << table_bits;
        one       = 64'd1 << frac_bits;
        x         = (64'(k) * HALFPI_Q30 + (n_entries >> 1)) >> table_bits;
        x2        = (x * x) >> 30;
        sum       = $signed(x);
        term      = x;
        for (int n = 0; n < 8; n++) begin
            term = ((term * x2) >> 30) / SERIES_DIV[n];
            if ((n % 2) == 0) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        e = ((64'(sum) << frac_bits) + (64'd1 << 29)) >> 30;
        if (e > one) begin
            e = one;
        end
        return SINE_W'(e);
    endfunction

endpackage

// File: hdl/sprite_quad_expander_core.sv
// Sprite quad expander.
// One request on the sprite channel carries a center, size, angle, texture
// rectangle, tint and a batch-start flag. The block answers with four
// requests on the vertex channel, corners in the order bottom-left,
// bottom-right, top-right, top-left, the last one flagged with last.
// Both channels use valid / stall: a request moves on a rising edge with
// valid high and stall low.
// Path: a sprite passes the input, trig, product, corner-sum and sequencer
// registers to the vertex output register; the other three vertices follow
// on consecutive cycles when not stalled. Throughput: one vertex per cycle
// while vertex_stall is low, with no gap between sprites. A five-stage
// pipeline (input, trig table, products, corner sums, corner sequencer with
// output register) keeps several sprites in flight; sprite_stall rises once
// every stage holds a sprite and none of them can advance.
// Reset clears all valid flags and the running vertex number; no vertex is
// shown until a sprite arrives.
// When vertex_stall is high the current vertex holds; the pipeline fills
// behind it and then stalls the sprite channel.
module sprite_quad_expander_core
    import sqe_pkg::*;
#(
    parameter int TABLE_BITS     = TABLE_BITS_DEF,
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    sprite_valid,
    output logic    sprite_stall,
    input  sprite_t sprite,
    output logic    vertex_valid,
    input  logic    vertex_stall,
    output vertex_t vertex
);

    logic       trig_in_ready;
    logic       trig_valid;
    logic       trig_ready;
    trig_item_t trig_item;
    logic       rot_valid;
    logic       rot_ready;
    rot_item_t  rot_item;

    assign sprite_stall = !trig_in_ready;

    // Angle to cos / sin and half extents.
    sqe_trig #(
        .TABLE_BITS     (TABLE_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_trig (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sprite_valid),
        .in_ready  (trig_in_ready),
        .in_data   (sprite),
        .out_valid (trig_valid),
        .out_ready (trig_ready),
        .out_data  (trig_item)
    );

    // Rotate corner offsets.
    sqe_rotate #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (trig_valid),
        .in_ready  (trig_ready),
        .in_data   (trig_item),
        .out_valid (rot_valid),
        .out_ready (rot_ready),
        .out_data  (rot_item)
    );

    // Sequence the four corners onto the vertex channel.
    sqe_expand u_expand (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rot_valid),
        .in_ready  (rot_ready),
        .in_data   (rot_item),
        .out_valid (vertex_valid),
        .out_ready (!vertex_stall),
        .out_data  (vertex)
    );

endmodule

// File: hdl/sqe_trig.sv
module sqe_trig
    import sqe_pkg::*;
#(
    parameter int TABLE_BITS     = TABLE_BITS_DEF,
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  sprite_t    in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output trig_item_t out_data
);

    localparam int TBL_N = 1 << TABLE_BITS;
    localparam int IDX_W = TABLE_BITS + 1;
    localparam int SHIFT = 14 - TABLE_BITS;
    localparam logic [14:0]      ROUND_STEP = 15'((1 << SHIFT) >> 1);
    localparam logic [IDX_W-1:0] IDX_MAX    = IDX_W'(TBL_N);

    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;
    localparam logic [1:0] QUAD_FOURTH = 2'd3;

    localparam logic signed [TRIG_W-1:0] TAN_MAX = TRIG_W'(32767);
    localparam logic signed [TRIG_W-1:0] TAN_MIN = ~TAN_MAX;

    logic [SINE_W-1:0] sine_rom [TBL_N+1];

    sprite_t    sprite_reg;
    logic       sprite_valid_reg;
    trig_item_t trig_reg;
    trig_item_t trig_next;
    logic       trig_valid_reg;
    logic       trig_ready;

    logic [14:0]              idx_sum;
    logic [IDX_W-1:0]         idx_raw;
    logic [IDX_W-1:0]         idx;
    logic signed [TRIG_W-1:0] sv;
    logic signed [TRIG_W-1:0] cv;

    function automatic logic signed [15:0] tan_clip(input logic signed [TRIG_W-1:0] v);
        if (v > TAN_MAX) begin
            return 16'sh7FFF;
        end
        if (v < TAN_MIN) begin
            return 16'sh8000;
        end
        return 16'(v);
    endfunction

    // Build the quarter-wave sine table as constants.
    generate
        for (genvar k = 0; k <= TBL_N; k++) begin : g_rom
            assign sine_rom[k] = sine_entry(TABLE_BITS, TRIG_FRAC_BITS, k);
        end
    endgenerate

    // Advance the two stages when the next one can take a request.
    assign trig_ready = !trig_valid_reg || out_ready;
    assign in_ready   = !sprite_valid_reg || trig_ready;
    assign out_valid  = trig_valid_reg;
    assign out_data   = trig_reg;

    // Round the angle to a table index and fold by quadrant.
    always_comb
    begin
        idx_sum = {1'b0, sprite_reg.angle[13:0]} + ROUND_STEP;
        idx_raw = IDX_W'(idx_sum >> SHIFT);
        idx     = (idx_raw > IDX_MAX) ? IDX_MAX : idx_raw;
        sv      = TRIG_W'(sine_rom[idx]);
        cv      = TRIG_W'(sine_rom[IDX_MAX - idx]);

        trig_next.half_x = sprite_reg.size_x[30:1];
        trig_next.half_y = sprite_reg.size_y[30:1];
        unique case (sprite_reg.angle[15:14])
            QUAD_FIRST:
            begin
                trig_next.sin_val = sv;
                trig_next.cos_val = cv;
            end
            QUAD_SECOND:
            begin
                trig_next.sin_val = cv;
                trig_next.cos_val = -sv;
            end
            QUAD_THIRD:
            begin
                trig_next.sin_val = -sv;
                trig_next.cos_val = -cv;
            end
            QUAD_FOURTH:
            begin
                trig_next.sin_val = -cv;
                trig_next.cos_val = sv;
            end
            default:
            begin
                trig_next.sin_val = sv;
                trig_next.cos_val = cv;
            end
        endcase

        trig_next.attr.center_x       = sprite_reg.center_x;
        trig_next.attr.center_y       = sprite_reg.center_y;
        trig_next.attr.tangent_x      = tan_clip(trig_next.cos_val);
        trig_next.attr.tangent_y      = tan_clip(trig_next.sin_val);
        trig_next.attr.u_first        = sprite_reg.u_first;
        trig_next.attr.v_first        = sprite_reg.v_first;
        trig_next.attr.u_second       = sprite_reg.u_second;
        trig_next.attr.v_second       = sprite_reg.v_second;
        trig_next.attr.tint           = sprite_reg.tint;
        trig_next.attr.first_of_batch = sprite_reg.first_of_batch;
    end

    // Track stage occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sprite_valid_reg <= 1'b0;
            trig_valid_reg   <= 1'b0;
        end else begin
            if (in_ready) begin
                sprite_valid_reg <= in_valid;
            end
            if (trig_ready) begin
                trig_valid_reg <= sprite_valid_reg;
            end
        end
    end

    // Hold payload until the stage advances.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            sprite_reg <= in_data;
        end
        if (trig_ready && sprite_valid_reg) begin
            trig_reg <= trig_next;
        end
    end

endmodule

// File: hdl/sqe_rotate.sv
module sqe_rotate
    import sqe_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  trig_item_t in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output rot_item_t  out_data
);

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(64'd1 << (TRIG_FRAC_BITS - 1));

    typedef struct packed {
        logic signed [PROD_W-1:0] hc;   // half_x * cos
        logic signed [PROD_W-1:0] hs;   // half_x * sin
        logic signed [PROD_W-1:0] kc;   // half_y * cos
        logic signed [PROD_W-1:0] ks;   // half_y * sin
        sprite_attr_t             attr;
    } prod_t;

    prod_t     prod_reg;
    prod_t     prod_next;
    logic      prod_valid_reg;
    logic      prod_ready;
    rot_item_t rot_reg;
    rot_item_t rot_next;
    logic      rot_valid_reg;
    logic      rot_ready;

    logic signed [HALF_W:0]   hx_s;
    logic signed [HALF_W:0]   hy_s;
    logic signed [TRIG_W-1:0] cos_s;
    logic signed [TRIG_W-1:0] sin_s;

    assign rot_ready  = !rot_valid_reg || out_ready;
    assign prod_ready = !prod_valid_reg || rot_ready;
    assign in_ready   = prod_ready;
    assign out_valid  = rot_valid_reg;
    assign out_data   = rot_reg;

    // Form the four half-extent products once per sprite.
    always_comb
    begin
        hx_s  = $signed({1'b0, in_data.half_x});
        hy_s  = $signed({1'b0, in_data.half_y});
        cos_s = in_data.cos_val;
        sin_s = in_data.sin_val;
        prod_next.hc   = hx_s * cos_s;
        prod_next.hs   = hx_s * sin_s;
        prod_next.kc   = hy_s * cos_s;
        prod_next.ks   = hy_s * sin_s;
        prod_next.attr = in_data.attr;
    end

    // Combine products per corner, round half up and drop the fraction.
    always_comb
    begin
        logic signed [SUM_W-1:0] hc_e;
        logic signed [SUM_W-1:0] hs_e;
        logic signed [SUM_W-1:0] kc_e;
        logic signed [SUM_W-1:0] ks_e;
        logic signed [SUM_W-1:0] sum_x;
        logic signed [SUM_W-1:0] sum_y;
        hc_e = SUM_W'(prod_reg.hc);
        hs_e = SUM_W'(prod_reg.hs);
        kc_e = SUM_W'(prod_reg.kc);
        ks_e = SUM_W'(prod_reg.ks);
        for (int i = 0; i < 4; i++) begin
            sum_x = (LEFT_CORNERS[i] ? -hc_e : hc_e)
                  + (BOTTOM_CORNERS[i] ? ks_e : -ks_e) + ROUND_HALF;
            sum_y = (LEFT_CORNERS[i] ? -hs_e : hs_e)
                  + (BOTTOM_CORNERS[i] ? -kc_e : kc_e) + ROUND_HALF;
            rot_next.off_x[i] = OFS_W'(sum_x >>> TRIG_FRAC_BITS);
            rot_next.off_y[i] = OFS_W'(sum_y >>> TRIG_FRAC_BITS);
        end
        rot_next.attr = prod_reg.attr;
    end

    // Track stage occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            prod_valid_reg <= 1'b0;
            rot_valid_reg  <= 1'b0;
        end else begin
            if (prod_ready) begin
                prod_valid_reg <= in_valid;
            end
            if (rot_ready) begin
                rot_valid_reg <= prod_valid_reg;
            end
        end
    end

    // Hold payload until the stage advances.
    always_ff @(posedge clk)
    begin
        if (prod_ready && in_valid) begin
            prod_reg <= prod_next;
        end
        if (rot_ready && prod_valid_reg) begin
            rot_reg <= rot_next;
        end
    end

endmodule

// File: hdl/sqe_expand.sv
module sqe_expand
    import sqe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  rot_item_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output vertex_t   out_data
);

    localparam logic signed [POS_W-1:0] POS_MAX = POS_W'(2147483647);
    localparam logic signed [POS_W-1:0] POS_MIN = ~POS_MAX;

    rot_item_t   item_reg;
    logic        busy_reg;
    logic [1:0]  corner_reg;
    logic [31:0] count_reg;
    logic [31:0] count_next;
    vertex_t     vertex_reg;
    vertex_t     vertex_next;
    logic        vertex_valid_reg;
    logic        out_free;
    logic        fire;
    logic        take;

    logic signed [OFS_W-1:0] off_x_sel;
    logic signed [OFS_W-1:0] off_y_sel;
    logic signed [POS_W-1:0] sum_x;
    logic signed [POS_W-1:0] sum_y;

    function automatic logic signed [31:0] sat32(input logic signed [POS_W-1:0] v);
        if (v > POS_MAX) begin
            return 32'sh7FFFFFFF;
        end
        if (v < POS_MIN) begin
            return 32'sh80000000;
        end
        return 32'(v);
    endfunction

    // Emit a corner whenever a sprite is held and the output register is free.
    assign out_free  = !vertex_valid_reg || out_ready;
    assign fire      = busy_reg && out_free;
    assign in_ready  = !busy_reg || (fire && corner_reg == LAST_CORNER);
    assign take      = in_ready && in_valid;
    assign out_valid = vertex_valid_reg;
    assign out_data  = vertex_reg;

    // Build the vertex for the current corner.
    always_comb
    begin
        off_x_sel = $signed(item_reg.off_x[corner_reg]);
        off_y_sel = $signed(item_reg.off_y[corner_reg]);
        sum_x     = POS_W'(item_reg.attr.center_x) + POS_W'(off_x_sel);
        sum_y     = POS_W'(item_reg.attr.center_y) + POS_W'(off_y_sel);

        vertex_next.pos_x       = sat32(sum_x);
        vertex_next.pos_y       = sat32(sum_y);
        vertex_next.tex_u       = LEFT_CORNERS[corner_reg] ? item_reg.attr.u_first
                                                           : item_reg.attr.u_second;
        vertex_next.tex_v       = BOTTOM_CORNERS[corner_reg] ? item_reg.attr.v_second
                                                             : item_reg.attr.v_first;
        vertex_next.tangent_x   = item_reg.attr.tangent_x;
        vertex_next.tangent_y   = item_reg.attr.tangent_y;
        vertex_next.vertex_tint = item_reg.attr.tint;
        if (corner_reg == FIRST_CORNER && item_reg.attr.first_of_batch) begin
            vertex_next.vertex_number = '0;
        end else begin
            vertex_next.vertex_number = count_reg;
        end
        vertex_next.corner = corner_reg;
        vertex_next.last   = (corner_reg == LAST_CORNER);
        count_next         = vertex_next.vertex_number + 32'd1;
    end

    // Advance the corner sequence, vertex count and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg         <= 1'b0;
            corner_reg       <= FIRST_CORNER;
            count_reg        <= '0;
            vertex_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                busy_reg   <= 1'b1;
                corner_reg <= FIRST_CORNER;
            end else if (fire) begin
                if (corner_reg == LAST_CORNER) begin
                    busy_reg <= 1'b0;
                end
                corner_reg <= corner_reg + 2'd1;
            end
            if (fire) begin
                count_reg        <= count_next;
                vertex_valid_reg <= 1'b1;
            end else if (out_ready) begin
                vertex_valid_reg <= 1'b0;
            end
        end
    end

    // Hold sprite and vertex payloads.
    always_ff @(posedge clk)
    begin
        if (take) begin
            item_reg <= in_data;
        end
        if (fire) begin
            vertex_reg <= vertex_next;
        end
    end

endmodule

// File: hdl/sqe_checker.sv
`include "assert_macros.svh"

module sqe_checker
    import sqe_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    vertex_valid,
    input logic    vertex_stall,
    input vertex_t vertex
);

    // A stalled vertex holds.
    `SQE_ASSERT_NEXT(a_vertex_hold, clk, rst_n, vertex_valid && vertex_stall, vertex_valid && $stable(vertex))

    // The last flag marks exactly the final corner.
    `SQE_ASSERT_IMPL(a_last_corner, clk, rst_n, vertex_valid, vertex.last == (vertex.corner == LAST_CORNER))

    // Corners of one sprite follow without a bubble.
    `SQE_ASSERT_NEXT(a_corner_step, clk, rst_n, vertex_valid && !vertex_stall && !vertex.last, vertex_valid && (vertex.corner == $past(vertex.corner) + 2'd1))

    // Numbering and tint run on within a sprite.
    `SQE_ASSERT_NEXT(a_number_step, clk, rst_n, vertex_valid && !vertex_stall && !vertex.last, (vertex.vertex_number == $past(vertex.vertex_number) + 32'd1) && (vertex.vertex_tint == $past(vertex.vertex_tint)))

    // A new sprite starts at the first corner.
    `SQE_ASSERT_NEXT(a_corner_restart, clk, rst_n, vertex_valid && !vertex_stall && vertex.last, !vertex_valid || (vertex.corner == FIRST_CORNER))

endmodule

bind sprite_quad_expander_core sqe_checker u_sqe_checker (.*);
